// ===== design/ifhp_pkg.sv =====
// ifhp_pkg: shared types and constants for the ipv4 flow header parser
// with flow dedup. No dependencies.
package ifhp_pkg;

  localparam int unsigned FLOW_ENTRIES_DEF = 4096;
  localparam int unsigned QUEUE_DEPTH      = 4;
  localparam int unsigned WINDOW_W         = 40;
  localparam int unsigned ENTRY_W          = 129;

  localparam logic [WINDOW_W-1:0] WINDOW_RESET = 40'd100000000;
  localparam logic [15:0] ETH_IPV4  = 16'h0800;
  localparam logic [7:0]  PROTO_TCP = 8'd6;
  localparam logic [7:0]  PROTO_UDP = 8'd17;

  localparam logic OP_BYTE = 1'b0;
  localparam logic OP_READ = 1'b1;

  localparam logic RK_EVENT   = 1'b0;
  localparam logic RK_COUNTER = 1'b1;

  localparam logic [1:0] CFG_WINDOW = 2'd0;
  localparam logic [1:0] CFG_TCP_EN = 2'd1;
  localparam logic [1:0] CFG_UDP_EN = 2'd2;

  typedef enum logic [2:0] {
    CNT_TOTAL,
    CNT_IPV4,
    CNT_TCP,
    CNT_UDP,
    CNT_SUBMIT,
    CNT_DROP,
    CNT_DEDUP,
    CNT_PERR
  } cnt_idx_t;

  typedef struct packed {
    logic        op;
    logic [7:0]  data_byte;
    logic        last;
    logic        direction;
    logic [63:0] stamp;
    logic [2:0]  counter_index;
  } in_item_t;

  typedef struct packed {
    logic        result_kind;
    logic [63:0] event_time;
    logic [31:0] source_address;
    logic [31:0] dest_address;
    logic [15:0] source_port;
    logic [15:0] dest_port;
    logic [15:0] ip_total_length;
    logic [7:0]  ip_protocol;
    logic [5:0]  flag_bits;
    logic        event_direction;
    logic [63:0] counter_value;
  } out_item_t;

  typedef struct packed {
    logic        is_read;
    logic [2:0]  cidx;
    logic [7:0]  bump;
    logic        lookup;
    logic [31:0] src;
    logic [31:0] dst;
    logic [31:0] ports;
    logic [15:0] length;
    logic [7:0]  proto;
    logic [5:0]  flags;
    logic        dir;
    logic [63:0] ts;
  } desc_t;

  typedef struct packed {
    logic clearing;
  } back_status_t;

endpackage

// ===== design/ifhp_ram.sv =====
// ifhp_ram: generic single write port ram with registered read.
// No dependencies.
module ifhp_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end
endmodule

// ===== design/ifhp_front.sv =====
// ifhp_front: byte parser; captures header fields and classifies each packet
// end or counter read into a descriptor. Depends on ifhp_pkg.
module ifhp_front (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  pkt_valid,
  output logic                  pkt_stall,
  input  ifhp_pkg::in_item_t    pkt,
  input  logic                  tcp_enable,
  input  logic                  udp_enable,
  input  logic                  q_full,
  input  ifhp_pkg::back_status_t status,
  output logic                  q_push,
  output ifhp_pkg::desc_t       q_desc
);
  import ifhp_pkg::*;

  logic [6:0]  byte_position;
  logic [15:0] ether_type;
  logic [3:0]  header_length_words;
  logic [7:0]  captured_protocol;
  logic [31:0] captured_source;
  logic [31:0] captured_dest;
  logic [15:0] captured_length;
  logic [31:0] captured_ports;
  logic [5:0]  captured_flags;

  logic [15:0] et_next;
  logic [3:0]  ihl_next;
  logic [7:0]  proto_next;
  logic [31:0] src_next;
  logic [31:0] dst_next;
  logic [15:0] len_next;
  logic [31:0] ports_next;
  logic [5:0]  flags_next;

  logic [6:0]  pos;
  logic [7:0]  b;
  logic [6:0]  t_cur;
  logic [1:0]  addr_byte;
  logic [1:0]  port_off;
  logic [6:0]  t_fin;
  logic [6:0]  need;
  logic [7:0]  plen;
  logic        is_tcp;
  logic        is_udp;
  logic        accept;
  desc_t       d;

  assign pos       = byte_position;
  assign b         = pkt.data_byte;
  assign t_cur     = 7'd14 + {1'b0, header_length_words, 2'b00};
  assign addr_byte = 2'(pos[1:0] - 2'd2);
  assign port_off  = 2'(pos - t_cur);

  always_comb begin
    et_next    = ether_type;
    ihl_next   = header_length_words;
    proto_next = captured_protocol;
    src_next   = captured_source;
    dst_next   = captured_dest;
    len_next   = captured_length;
    ports_next = captured_ports;
    flags_next = captured_flags;
    case (pos) inside
      7'd12: et_next[15:8] = b;
      7'd13: et_next[7:0] = b;
      7'd14: ihl_next = b[3:0];
      7'd16: len_next[15:8] = b;
      7'd17: len_next[7:0] = b;
      7'd23: proto_next = b;
      [7'd26:7'd29]: src_next[{addr_byte, 3'b000} +: 8] = b;
      [7'd30:7'd33]: dst_next[{addr_byte, 3'b000} +: 8] = b;
      default: ;
    endcase
    if (pos >= 7'd15) begin
      if (pos >= t_cur && pos < t_cur + 7'd4) begin
        ports_next[{2'd3 - port_off, 3'b000} +: 8] = b;
      end
      if (pos == t_cur + 7'd13) begin
        flags_next = b[5:0];
      end
    end
  end

  // packet end classification
  assign plen   = {1'b0, pos} + 8'd1;
  assign is_tcp = (proto_next == PROTO_TCP);
  assign is_udp = (proto_next == PROTO_UDP);
  assign t_fin  = 7'd14 + {1'b0, ihl_next, 2'b00};
  assign need   = t_fin + (is_tcp ? 7'd20 : 7'd8);

  always_comb begin
    d         = '0;
    d.is_read = (pkt.op == OP_READ);
    d.cidx    = pkt.counter_index;
    d.src     = src_next;
    d.dst     = dst_next;
    d.ports   = ports_next;
    d.length  = len_next;
    d.proto   = proto_next;
    d.flags   = is_tcp ? flags_next : 6'd0;
    d.dir     = pkt.direction;
    d.ts      = pkt.stamp;
    if (pkt.op == OP_BYTE) begin
      d.bump[CNT_TOTAL] = 1'b1;
      if (plen >= 8'd14 && et_next == ETH_IPV4) begin
        if (plen < 8'd34) begin
          d.bump[CNT_PERR] = 1'b1;
        end else begin
          d.bump[CNT_IPV4] = 1'b1;
          if (is_tcp || is_udp) begin
            if (ihl_next < 4'd5) begin
              d.bump[CNT_PERR] = 1'b1;
            end else if ((is_tcp && tcp_enable) || (is_udp && udp_enable)) begin
              if (plen < {1'b0, need}) begin
                d.bump[CNT_PERR] = 1'b1;
              end else begin
                d.bump[CNT_TCP] = is_tcp;
                d.bump[CNT_UDP] = is_udp;
                d.lookup        = 1'b1;
              end
            end
          end
        end
      end
    end
  end

  assign pkt_stall = q_full || status.clearing;
  assign accept    = pkt_valid && !pkt_stall;
  assign q_push    = accept && (pkt.op == OP_READ || pkt.last);
  assign q_desc    = d;

  always_ff @(posedge clk) begin
    if (rst || (accept && pkt.op == OP_BYTE && pkt.last)) begin
      byte_position       <= '0;
      ether_type          <= '0;
      header_length_words <= '0;
      captured_protocol   <= '0;
      captured_source     <= '0;
      captured_dest       <= '0;
      captured_length     <= '0;
      captured_ports      <= '0;
      captured_flags      <= '0;
    end else if (accept && pkt.op == OP_BYTE) begin
      if (pos != 7'd127) begin
        byte_position <= pos + 7'd1;
      end
      ether_type          <= et_next;
      header_length_words <= ihl_next;
      captured_protocol   <= proto_next;
      captured_source     <= src_next;
      captured_dest       <= dst_next;
      captured_length     <= len_next;
      captured_ports      <= ports_next;
      captured_flags      <= flags_next;
    end
  end
endmodule

// ===== design/ifhp_queue.sv =====
// ifhp_queue: short descriptor fifo between parser and dedup back end.
// Depends on ifhp_pkg.
module ifhp_queue (
  input  logic            clk,
  input  logic            rst,
  input  logic            push,
  input  ifhp_pkg::desc_t wdata,
  output logic            full,
  input  logic            pop,
  output logic            not_empty,
  output ifhp_pkg::desc_t rdata
);
  import ifhp_pkg::*;

  localparam int unsigned PW = $clog2(QUEUE_DEPTH);

  desc_t         slots [QUEUE_DEPTH];
  logic [PW-1:0] wr_ptr;
  logic [PW-1:0] rd_ptr;
  logic [PW:0]   count;

  assign full      = (count == (PW+1)'(QUEUE_DEPTH));
  assign not_empty = (count != '0);
  assign rdata     = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      count <= count + (PW+1)'(push) - (PW+1)'(pop);
    end
  end
endmodule

// ===== design/ifhp_back.sv =====
// ifhp_back: dedup lookup, statistics counters and result register.
// Depends on ifhp_pkg and ifhp_ram.
module ifhp_back #(
  parameter int unsigned FLOW_ENTRIES = ifhp_pkg::FLOW_ENTRIES_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic [ifhp_pkg::WINDOW_W-1:0] window,
  input  logic                          q_valid,
  input  ifhp_pkg::desc_t               q_desc,
  output logic                          q_pop,
  output ifhp_pkg::back_status_t        status,
  output logic                          res_valid,
  input  logic                          res_stall,
  output ifhp_pkg::out_item_t           res
);
  import ifhp_pkg::*;

  localparam int unsigned SW = $clog2(FLOW_ENTRIES);

  typedef struct packed {
    logic        valid;
    logic [63:0] key;
    logic [63:0] time_ns;
  } entry_t;

  logic          clearing;
  logic [SW-1:0] clear_idx;

  logic          b_valid;
  desc_t         b_desc;
  logic [63:0]   b_key;
  logic [SW-1:0] b_slot;
  logic          byp_hit;
  entry_t        byp_entry;

  logic [63:0]   cnt [8];

  logic [63:0]   q_key;
  logic [31:0]   q_fold;
  logic [SW-1:0] q_slot;
  logic          b_adv;
  logic          b_fire;
  entry_t        rd_entry;
  entry_t        cur;
  logic [63:0]   age;
  logic          dup;
  logic          emit;
  logic [7:0]    bump;
  out_item_t     res_next;

  logic          ram_we;
  logic [SW-1:0] ram_waddr;
  entry_t        ram_wdata;
  logic [ENTRY_W-1:0] ram_rdata;

  assign status.clearing = clearing;

  assign q_key  = {q_desc.src, q_desc.dst} ^ {32'd0, q_desc.ports};
  assign q_fold = q_key[63:32] ^ q_key[31:0];
  assign q_slot = q_fold[SW-1:0];

  assign b_adv  = !res_valid || !res_stall;
  assign b_fire = b_valid && b_adv;
  assign q_pop  = q_valid && !clearing && (!b_valid || b_adv);

  assign rd_entry = entry_t'(ram_rdata);
  assign cur      = byp_hit ? byp_entry : rd_entry;
  assign age      = b_desc.ts - cur.time_ns;
  assign dup      = b_desc.lookup && cur.valid && (cur.key == b_key)
                    && (age < {24'd0, window});
  assign emit     = b_desc.is_read || (b_desc.lookup && !dup);

  always_comb begin
    bump             = b_desc.is_read ? 8'd0 : b_desc.bump;
    bump[CNT_SUBMIT] = !b_desc.is_read && b_desc.lookup && !dup;
    bump[CNT_DEDUP]  = !b_desc.is_read && dup;
  end

  always_comb begin
    res_next = '0;
    if (b_desc.is_read) begin
      res_next.result_kind   = RK_COUNTER;
      res_next.counter_value = cnt[b_desc.cidx];
    end else begin
      res_next.result_kind     = RK_EVENT;
      res_next.event_time      = b_desc.ts;
      res_next.source_address  = b_desc.src;
      res_next.dest_address    = b_desc.dst;
      res_next.source_port     = b_desc.ports[31:16];
      res_next.dest_port       = b_desc.ports[15:0];
      res_next.ip_total_length = b_desc.length;
      res_next.ip_protocol     = b_desc.proto;
      res_next.flag_bits       = b_desc.flags;
      res_next.event_direction = b_desc.dir;
    end
  end

  assign ram_we    = clearing || (b_fire && !b_desc.is_read && b_desc.lookup && !dup);
  assign ram_waddr = clearing ? clear_idx : b_slot;
  assign ram_wdata = clearing ? entry_t'('0)
                              : entry_t'{valid: 1'b1, key: b_key, time_ns: b_desc.ts};

  ifhp_ram #(
    .WIDTH(ENTRY_W),
    .DEPTH(FLOW_ENTRIES)
  ) u_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ENTRY_W'(ram_wdata)),
    .re   (q_pop),
    .raddr(q_slot),
    .rdata(ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      clearing  <= 1'b1;
      clear_idx <= '0;
      b_valid   <= 1'b0;
      byp_hit   <= 1'b0;
      res_valid <= 1'b0;
      for (int k = 0; k < 8; k++) begin
        cnt[k] <= '0;
      end
    end else begin
      if (clearing) begin
        clear_idx <= clear_idx + 1'b1;
        if (clear_idx == SW'(FLOW_ENTRIES - 1)) begin
          clearing <= 1'b0;
        end
      end
      if (q_pop) begin
        b_valid   <= 1'b1;
        b_desc    <= q_desc;
        b_key     <= q_key;
        b_slot    <= q_slot;
        byp_hit   <= ram_we && (ram_waddr == q_slot);
        byp_entry <= ram_wdata;
      end else if (b_adv) begin
        b_valid <= 1'b0;
      end
      if (b_fire) begin
        for (int k = 0; k < 8; k++) begin
          if (bump[k]) begin
            cnt[k] <= cnt[k] + 64'd1;
          end
        end
      end
      if (b_adv) begin
        res_valid <= b_fire && emit;
      end
      if (b_fire && emit) begin
        res <= res_next;
      end
    end
  end

`ifndef SYNTHESIS
  a_no_pop_clearing: assert property (@(posedge clk) disable iff (rst)
    clearing |-> !q_pop) else $error("pop during clear pass");
  a_dedup_count: assert property (@(posedge clk) disable iff (rst)
    (b_fire && bump[CNT_DEDUP]) |=> cnt[CNT_DEDUP] == $past(cnt[CNT_DEDUP]) + 64'd1)
    else $error("dedup hit not counted");
  a_res_source: assert property (@(posedge clk) disable iff (rst)
    $rose(res_valid) |-> $past(b_valid)) else $error("result without item");
  a_write_lookup: assert property (@(posedge clk) disable iff (rst)
    (ram_we && !clearing) |-> (b_desc.lookup && !dup)) else $error("bad flow write");
`endif
endmodule

// ===== design/ipv4_flow_header_parser_dedup_unit.sv =====
// ipv4_flow_header_parser_dedup_unit: top level with config registers.
// Depends on ifhp_pkg, ifhp_front, ifhp_queue, ifhp_back.
//
// Takes one packet byte or counter read per cycle while pkt_stall is low. The
// parser captures the Ethernet, IPv4 and TCP/UDP fields and at packet end
// hands a classified descriptor through a four-entry queue to the back end,
// which looks up the direct-mapped flow table (one ram read and at most one
// write per packet), updates the statistics and registers the result. It
// sustains one item per cycle unless stalled; the last byte or counter read
// passes the queue, the lookup stage and the result register, held only
// while res_stall holds earlier results. After reset the flow table is swept
// clear with pkt_stall high. FLOW_ENTRIES must be a power of two.
module ipv4_flow_header_parser_dedup_unit #(
  parameter int unsigned FLOW_ENTRIES = ifhp_pkg::FLOW_ENTRIES_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                pkt_valid,
  output logic                pkt_stall,
  input  ifhp_pkg::in_item_t  pkt,
  output logic                res_valid,
  input  logic                res_stall,
  output ifhp_pkg::out_item_t res,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [1:0]          cfg_index,
  input  logic [39:0]         cfg_data
);
  import ifhp_pkg::*;

  logic [WINDOW_W-1:0] window;
  logic                tcp_enable;
  logic                udp_enable;

  logic         q_push;
  desc_t        q_wdata;
  logic         q_full;
  logic         q_pop;
  logic         q_valid;
  desc_t        q_rdata;
  back_status_t status;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      window     <= WINDOW_RESET;
      tcp_enable <= 1'b1;
      udp_enable <= 1'b1;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_WINDOW: window <= cfg_data;
        CFG_TCP_EN: tcp_enable <= cfg_data[0];
        CFG_UDP_EN: udp_enable <= cfg_data[0];
        default: ;
      endcase
    end
  end

  ifhp_front u_front (
    .clk       (clk),
    .rst       (rst),
    .pkt_valid (pkt_valid),
    .pkt_stall (pkt_stall),
    .pkt       (pkt),
    .tcp_enable(tcp_enable),
    .udp_enable(udp_enable),
    .q_full    (q_full),
    .status    (status),
    .q_push    (q_push),
    .q_desc    (q_wdata)
  );

  ifhp_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (q_push),
    .wdata    (q_wdata),
    .full     (q_full),
    .pop      (q_pop),
    .not_empty(q_valid),
    .rdata    (q_rdata)
  );

  ifhp_back #(
    .FLOW_ENTRIES(FLOW_ENTRIES)
  ) u_back (
    .clk      (clk),
    .rst      (rst),
    .window   (window),
    .q_valid  (q_valid),
    .q_desc   (q_rdata),
    .q_pop    (q_pop),
    .status   (status),
    .res_valid(res_valid),
    .res_stall(res_stall),
    .res      (res)
  );
endmodule
